// ----- rtl/grws_pkg.sv -----
// grws_pkg: shared codes and field widths of the grid roulette wheel sampler
// no dependencies; used by grid_roulette_wheel_sampler, grws_pick_checker and tb

package grws_pkg;

    // coordinate fields on the ports are six bits wide
    localparam int COORD_BITS     = 6;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int FRAC_BITS      = 32;
    localparam int IN_TDATA_BITS  = 64;
    localparam int OUT_TDATA_BITS = 16;
    localparam int CFG_IDX_BITS   = 2;

    // item kinds carried on tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_RIGHT  = 2'd1,
        CFG_BOTTOM = 2'd2,
        CFG_TOP    = 2'd3
    } t_cfg_idx;

    // register values after reset
    localparam logic [COORD_BITS-1:0] LEFT_RESET   = 6'd0;
    localparam logic [COORD_BITS-1:0] RIGHT_RESET  = 6'd63;
    localparam logic [COORD_BITS-1:0] BOTTOM_RESET = 6'd0;
    localparam logic [COORD_BITS-1:0] TOP_RESET    = 6'd63;

endpackage

// ----- rtl/grid_roulette_wheel_sampler.sv -----
// grid_roulette_wheel_sampler: weighted 2d cell picker over a grid of weights
// depends on grws_pkg for field widths, item kinds and register indexes

// The block keeps a grid of unsigned cell weights in a single-port-read memory
// plus a memory of per-row totals. A write item (tuser = 0) replaces one cell
// weight and fixes up its row total in the S_WR_UPD state; it gives no result.
// Writes to a cell outside the grid are dropped. A draw item (tuser = 1)
// carries a 32-bit fraction F: the block sums the rectangle set by the region
// registers into T, scales C = (T * F) >> 32, finds the first row whose running
// sum reaches C, then the first column in that row whose running sum reaches
// the rest, and returns the cell coordinates as one result item. Region bounds
// past the grid are clamped to its last row or column; an inverted bound
// collapses to the single lower row or column. Each memory hands out one
// entry per cycle, and that sets the draw time: when the rectangle spans the
// whole grid width the summing pass reads the row totals directly, otherwise
// each row's span is summed cell by cell. Only one item is worked on at a
// time; a finished result sits in the output register so the next item can
// be accepted while it waits. After reset the block clears the weight and row
// total memories, one entry per cycle, with s_axis_tready low; configuration
// writes are taken throughout.

module grid_roulette_wheel_sampler #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [grws_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [grws_pkg::COORD_BITS-1:0]        i_cfg_data,
    // input items
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cell_col[5:0], cell_row[11:6], cell_weight[27:12],
    // random_fraction[59:28], zero pad[63:60]
    input  logic [grws_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // command[0]
    input  logic [0:0]                             s_axis_tuser,
    // result items
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pick_col[5:0], pick_row[11:6], zero pad[15:12]
    output logic [grws_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);

    localparam int CB     = grws_pkg::COORD_BITS;
    localparam int CW     = $clog2(GRID_COLS);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int NCELLS = GRID_ROWS * GRID_COLS;
    localparam int AW     = $clog2(NCELLS);
    // a row sum holds GRID_COLS weights, the rectangle total GRID_ROWS rows
    localparam int RTW    = WEIGHT_BITS + CW;
    localparam int TW     = RTW + RW;
    // total split into a low 32-bit and a high part for the scaling multiply
    localparam int HW     = (TW > 32) ? TW - 32 : 1;
    localparam int XW     = 32 + HW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_UPD,
        S_SUM,
        S_MUL,
        S_SCALE,
        S_ROWS,
        S_COLS,
        S_OUT
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(GRID_COLS) + AW'(col);
    endfunction

    function automatic logic [CW-1:0] clamp_col(input logic [CB-1:0] v);
        if (32'(v) > GRID_COLS - 1) begin
            return CW'(GRID_COLS - 1);
        end
        return CW'(v);
    endfunction

    function automatic logic [RW-1:0] clamp_row(input logic [CB-1:0] v);
        if (32'(v) > GRID_ROWS - 1) begin
            return RW'(GRID_ROWS - 1);
        end
        return RW'(v);
    endfunction

    // ---------------------------------------------------------------- fields
    logic [CB-1:0]                        w_in_col;
    logic [CB-1:0]                        w_in_row;
    logic [grws_pkg::IN_WEIGHT_BITS-1:0]  w_in_weight;
    logic [grws_pkg::FRAC_BITS-1:0]       w_in_frac;
    logic                                 w_in_accept;

    assign w_in_col    = s_axis_tdata[5:0];
    assign w_in_row    = s_axis_tdata[11:6];
    assign w_in_weight = s_axis_tdata[27:12];
    assign w_in_frac   = s_axis_tdata[59:28];
    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------- registers
    t_state                          r_state;
    logic [AW-1:0]                   r_clr;
    logic [CB-1:0]                   r_region_left;
    logic [CB-1:0]                   r_region_right;
    logic [CB-1:0]                   r_region_bottom;
    logic [CB-1:0]                   r_region_top;

    // pending write
    logic [RW-1:0]                   r_wr_row;
    logic [CW-1:0]                   r_wr_col;
    logic [WEIGHT_BITS-1:0]          r_wr_weight;

    // draw: clamped rectangle and working values
    logic [CW-1:0]                   r_x1;
    logic [CW-1:0]                   r_x2;
    logic [RW-1:0]                   r_y1;
    logic [RW-1:0]                   r_y2;
    logic                            r_full;
    logic [grws_pkg::FRAC_BITS-1:0]  r_frac;
    logic [RTW-1:0]                  r_row_acc;
    logic [TW-1:0]                   r_total;
    logic [63:0]                     r_prod_lo;
    logic [XW-1:0]                   r_prod_hi;
    logic [TW-1:0]                   r_choose;
    logic [TW-1:0]                   r_cum;
    logic [RW-1:0]                   r_pick_row;
    logic [CW-1:0]                   r_pick_col;

    // read issue side and the matching data side, registered in the next cycle
    logic                            r_issuing;
    logic [RW-1:0]                   r_iss_row;
    logic [CW-1:0]                   r_iss_col;
    logic                            r_d_valid;
    logic [RW-1:0]                   r_d_row;
    logic [CW-1:0]                   r_d_col;
    logic                            r_d_rowend;
    logic                            r_d_last;

    // output register
    logic                            r_out_valid;
    logic [CB-1:0]                   r_out_col;
    logic [CB-1:0]                   r_out_row;

    // memories and their registered read data
    logic [WEIGHT_BITS-1:0]          r_weight_mem [NCELLS];
    logic [RTW-1:0]                  r_rt_mem     [GRID_ROWS];
    logic [RTW-1:0]                  r_span_mem   [GRID_ROWS];
    logic [WEIGHT_BITS-1:0]          r_weight_rd;
    logic [RTW-1:0]                  r_rt_rd;
    logic [RTW-1:0]                  r_span_rd;

    // ------------------------------------------------------ draw setup logic
    logic [CW-1:0]  w_x1;
    logic [CW-1:0]  w_x2;
    logic [RW-1:0]  w_y1;
    logic [RW-1:0]  w_y2;
    logic           w_wr_in_grid;

    always_comb begin
        w_x1 = clamp_col(r_region_left);
        w_x2 = clamp_col(r_region_right);
        w_y1 = clamp_row(r_region_bottom);
        w_y2 = clamp_row(r_region_top);
        // inverted bounds collapse to the lower edge
        if (w_x2 < w_x1) begin
            w_x2 = w_x1;
        end
        if (w_y2 < w_y1) begin
            w_y2 = w_y1;
        end
    end

    assign w_wr_in_grid = (32'(w_in_col) < GRID_COLS) && (32'(w_in_row) < GRID_ROWS);

    // -------------------------------------------------------- datapath terms
    logic [RTW-1:0] n_rt_new;
    logic [RTW-1:0] n_row_sum;
    logic [TW-1:0]  n_row_cum;
    logic           w_row_hit;
    logic [TW-1:0]  n_row_rem;
    logic [TW-1:0]  n_col_cum;
    logic           w_col_hit;
    logic [XW-1:0]  w_tot_ext;
    logic           w_row_end;
    logic           w_sum_last;

    // old weight leaves the row total, new weight joins it
    assign n_rt_new   = r_rt_rd - RTW'(r_weight_rd) + RTW'(r_wr_weight);
    // full-width rectangles take the stored row total instead of cell sums
    assign n_row_sum  = r_row_acc + (r_full ? r_rt_rd : RTW'(r_weight_rd));
    assign n_row_cum  = r_cum + TW'(r_span_rd);
    assign w_row_hit  = n_row_cum >= r_choose;
    // no hit means the last row, with every row counted
    assign n_row_rem  = w_row_hit ? (r_choose - r_cum) : (r_choose - n_row_cum);
    assign n_col_cum  = r_cum + TW'(r_weight_rd);
    assign w_col_hit  = n_col_cum >= r_choose;
    assign w_tot_ext  = XW'(r_total);
    assign w_row_end  = r_full || (r_iss_col == r_x2);
    assign w_sum_last = w_row_end && (r_iss_row == r_y2);

    // ------------------------------------------------------ memory addresses
    logic [AW-1:0]          w_wt_raddr;
    logic                   w_wt_we;
    logic [AW-1:0]          w_wt_waddr;
    logic [WEIGHT_BITS-1:0] w_wt_wdata;
    logic [RW-1:0]          w_rt_raddr;
    logic                   w_rt_we;
    logic [RW-1:0]          w_rt_waddr;
    logic [RTW-1:0]         w_rt_wdata;
    logic                   w_span_we;

    always_comb begin
        w_wt_raddr = cell_addr(r_iss_row, r_iss_col);
        w_rt_raddr = r_iss_row;
        w_wt_we    = 1'b0;
        w_wt_waddr = cell_addr(r_wr_row, r_wr_col);
        w_wt_wdata = r_wr_weight;
        w_rt_we    = 1'b0;
        w_rt_waddr = r_wr_row;
        w_rt_wdata = n_rt_new;
        case (r_state)
            S_CLEAR: begin
                w_wt_we    = 1'b1;
                w_wt_waddr = r_clr;
                w_wt_wdata = '0;
                w_rt_we    = 32'(r_clr) < GRID_ROWS;
                w_rt_waddr = RW'(r_clr);
                w_rt_wdata = '0;
            end
            S_IDLE: begin
                // fetch old weight and row total for a possible write item
                w_wt_raddr = cell_addr(RW'(w_in_row), CW'(w_in_col));
                w_rt_raddr = RW'(w_in_row);
            end
            S_WR_UPD: begin
                w_wt_we = 1'b1;
                w_rt_we = 1'b1;
            end
            S_COLS: begin
                w_wt_raddr = cell_addr(r_pick_row, r_iss_col);
            end
            default: begin
            end
        endcase
    end

    assign w_span_we = (r_state == S_SUM) && r_d_valid && r_d_rowend;

    always_ff @(posedge i_clk) begin
        if (w_wt_we) begin
            r_weight_mem[w_wt_waddr] <= w_wt_wdata;
        end
        r_weight_rd <= r_weight_mem[w_wt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rt_we) begin
            r_rt_mem[w_rt_waddr] <= w_rt_wdata;
        end
        r_rt_rd <= r_rt_mem[w_rt_raddr];
    end

    // per-row span of the rectangle, filled by the summing pass
    always_ff @(posedge i_clk) begin
        if (w_span_we) begin
            r_span_mem[r_d_row] <= n_row_sum;
        end
        r_span_rd <= r_span_mem[r_iss_row];
    end

    // ----------------------------------------------------- configuration regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_left   <= grws_pkg::LEFT_RESET;
            r_region_right  <= grws_pkg::RIGHT_RESET;
            r_region_bottom <= grws_pkg::BOTTOM_RESET;
            r_region_top    <= grws_pkg::TOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grws_pkg::CFG_LEFT:   r_region_left   <= i_cfg_data;
                grws_pkg::CFG_RIGHT:  r_region_right  <= i_cfg_data;
                grws_pkg::CFG_BOTTOM: r_region_bottom <= i_cfg_data;
                grws_pkg::CFG_TOP:    r_region_top    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------- control fsm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_issuing   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NCELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_wr_row    <= RW'(w_in_row);
                    r_wr_col    <= CW'(w_in_col);
                    r_wr_weight <= WEIGHT_BITS'(w_in_weight);
                    r_x1        <= w_x1;
                    r_x2        <= w_x2;
                    r_y1        <= w_y1;
                    r_y2        <= w_y2;
                    r_full      <= (w_x1 == '0) && (32'(w_x2) == GRID_COLS - 1);
                    r_frac      <= w_in_frac;
                    r_iss_row   <= w_y1;
                    r_iss_col   <= w_x1;
                    r_row_acc   <= '0;
                    r_total     <= '0;
                    r_d_valid   <= 1'b0;
                    if (w_in_accept) begin
                        if (s_axis_tuser[0] == grws_pkg::CMD_DRAW) begin
                            r_issuing <= 1'b1;
                            r_state   <= S_SUM;
                        end else if (w_wr_in_grid) begin
                            r_state <= S_WR_UPD;
                        end
                    end
                end
                S_WR_UPD: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    // issue one read a cycle across the rectangle
                    r_d_valid  <= r_issuing;
                    r_d_row    <= r_iss_row;
                    r_d_rowend <= w_row_end;
                    r_d_last   <= w_sum_last;
                    if (r_issuing) begin
                        if (w_sum_last) begin
                            r_issuing <= 1'b0;
                        end else if (w_row_end) begin
                            r_iss_row <= r_iss_row + 1'b1;
                            r_iss_col <= r_x1;
                        end else begin
                            r_iss_col <= r_iss_col + 1'b1;
                        end
                    end
                    // accumulate the data of the previous read
                    if (r_d_valid) begin
                        if (r_d_rowend) begin
                            r_row_acc <= '0;
                            r_total   <= r_total + TW'(n_row_sum);
                        end else begin
                            r_row_acc <= n_row_sum;
                        end
                        if (r_d_last) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod_lo <= w_tot_ext[31:0] * r_frac;
                    r_prod_hi <= w_tot_ext[XW-1:32] * r_frac;
                    r_state   <= S_SCALE;
                end
                S_SCALE: begin
                    r_choose  <= TW'(r_prod_hi + XW'(r_prod_lo[63:32]));
                    r_cum     <= '0;
                    r_iss_row <= r_y1;
                    r_issuing <= 1'b1;
                    r_d_valid <= 1'b0;
                    r_state   <= S_ROWS;
                end
                S_ROWS: begin
                    r_d_valid <= r_issuing;
                    r_d_row   <= r_iss_row;
                    r_d_last  <= r_iss_row == r_y2;
                    if (r_issuing) begin
                        if (r_iss_row == r_y2) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_iss_row <= r_iss_row + 1'b1;
                        end
                    end
                    if (r_d_valid) begin
                        if (w_row_hit || r_d_last) begin
                            // row found, or last row as the fallback
                            r_pick_row <= r_d_row;
                            r_choose   <= n_row_rem;
                            r_cum      <= '0;
                            r_iss_col  <= r_x1;
                            r_issuing  <= 1'b1;
                            r_d_valid  <= 1'b0;
                            r_state    <= S_COLS;
                        end else begin
                            r_cum <= n_row_cum;
                        end
                    end
                end
                S_COLS: begin
                    r_d_valid <= r_issuing;
                    r_d_col   <= r_iss_col;
                    r_d_last  <= r_iss_col == r_x2;
                    if (r_issuing) begin
                        if (r_iss_col == r_x2) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_iss_col <= r_iss_col + 1'b1;
                        end
                    end
                    if (r_d_valid) begin
                        if (w_col_hit || r_d_last) begin
                            r_pick_col <= r_d_col;
                            r_issuing  <= 1'b0;
                            r_d_valid  <= 1'b0;
                            r_state    <= S_OUT;
                        end else begin
                            r_cum <= n_col_cum;
                        end
                    end
                end
                S_OUT: begin
                    // wait for the output register to free up
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= CB'(r_pick_col);
                        r_out_row   <= CB'(r_pick_row);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_row, r_out_col};

    // ------------------------------------------------------------ assertions
    // the running row sum stays below the target until the row is picked
    a_row_cum_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS) |-> (r_cum == '0 || r_cum < r_choose))
        else $error("row search passed the target without a pick");

    // the picked cell lies inside the clamped rectangle
    a_pick_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_pick_col >= r_x1 && r_pick_col <= r_x2 &&
                                r_pick_row >= r_y1 && r_pick_row <= r_y2))
        else $error("picked cell outside the rectangle");

    // a result only appears out of the output state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

    // items are only taken once the whole memory has been cleared
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(s_axis_tready) && $past(r_state == S_CLEAR))
            |-> ($past(r_clr) == AW'(NCELLS - 1)))
        else $error("clearing pass ended early");

endmodule

// ----- tb/sv/grws_pick_checker.sv -----
// grws_pick_checker: watches the config port and both streams of the sampler,
// predicts each drawn cell from its own weight grid and compares the picks
// depends on grws_pkg for field widths, item kinds and register indexes
`timescale 1ns / 1ps

module grws_pick_checker
    import grws_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [COORD_BITS-1:0]      i_cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]   s_axis_tdata,
    input  logic [0:0]                 s_axis_tuser,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output int                         o_mismatches,
    output int                         o_picks_outstanding,
    output int                         o_picks_checked
);

    localparam int GRID_SIDE  = 64;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } cell_t;

    logic [IN_WEIGHT_BITS-1:0] weight_grid [GRID_SIDE][GRID_SIDE];
    logic [COORD_BITS-1:0]     region_left, region_right, region_bottom, region_top;
    cell_t                     expected_picks [$];
    int                        mismatches;
    int                        picks_checked;

    assign o_mismatches        = mismatches;
    assign o_picks_outstanding = expected_picks.size();
    assign o_picks_checked     = picks_checked;

    task automatic flag_error(input string msg);
        if (mismatches < PRINT_CAP)
            $display("checker: %s", msg);
        mismatches++;
    endtask

    function automatic longint unsigned span_weight(input int unsigned row,
                                                    input int unsigned x1,
                                                    input int unsigned x2);
        longint unsigned acc;
        acc = 0;
        for (int unsigned c = x1; c <= x2; c++)
            acc += weight_grid[row][c];
        return acc;
    endfunction

    // scale the rectangle total by the fraction, walk rows then columns
    function automatic cell_t predict_pick(input logic [FRAC_BITS-1:0] frac);
        int unsigned     x1, x2, y1, y2;
        longint unsigned total, target, run, span;
        cell_t           pick;
        x1 = region_left;
        x2 = (region_right < region_left) ? region_left : region_right;
        y1 = region_bottom;
        y2 = (region_top < region_bottom) ? region_bottom : region_top;
        total = 0;
        for (int unsigned r = y1; r <= y2; r++)
            total += span_weight(r, x1, x2);
        target = (total * {32'd0, frac}) >> 32;
        pick.row = y2[COORD_BITS-1:0];
        run = 0;
        for (int unsigned r = y1; r <= y2; r++) begin
            span = span_weight(r, x1, x2);
            if (run + span >= target) begin
                pick.row = r[COORD_BITS-1:0];
                break;
            end
            run += span;
        end
        target = (target >= run) ? target - run : 0;
        pick.col = x2[COORD_BITS-1:0];
        run = 0;
        for (int unsigned c = x1; c <= x2; c++) begin
            run += weight_grid[pick.row][c];
            if (run >= target) begin
                pick.col = c[COORD_BITS-1:0];
                break;
            end
        end
        return pick;
    endfunction

    always @(posedge i_clk) begin : monitor
        cell_t                     got, want;
        logic [COORD_BITS-1:0]     in_col, in_row;
        logic [IN_WEIGHT_BITS-1:0] in_wgt;
        logic [FRAC_BITS-1:0]      in_frac;
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_SIDE; r++)
                for (int c = 0; c < GRID_SIDE; c++)
                    weight_grid[r][c] = '0;
            region_left   = LEFT_RESET;
            region_right  = RIGHT_RESET;
            region_bottom = BOTTOM_RESET;
            region_top    = TOP_RESET;
            expected_picks.delete();
            mismatches    = 0;
            picks_checked = 0;
        end else begin
            // results leave before a newly accepted draw could produce one
            if (m_axis_tvalid && m_axis_tready) begin
                got.col = m_axis_tdata[5:0];
                got.row = m_axis_tdata[11:6];
                if (expected_picks.size() == 0) begin
                    flag_error($sformatf("pick col %0d row %0d with no draw waiting",
                                         got.col, got.row));
                end else begin
                    want = expected_picks.pop_front();
                    if (got.col != want.col)
                        flag_error($sformatf("pick %0d: pick_col %0d, expected %0d",
                                             picks_checked, got.col, want.col));
                    if (got.row != want.row)
                        flag_error($sformatf("pick %0d: pick_row %0d, expected %0d",
                                             picks_checked, got.row, want.row));
                    picks_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT:   region_left   = i_cfg_data;
                    CFG_RIGHT:  region_right  = i_cfg_data;
                    CFG_BOTTOM: region_bottom = i_cfg_data;
                    CFG_TOP:    region_top    = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_col  = s_axis_tdata[5:0];
                in_row  = s_axis_tdata[11:6];
                in_wgt  = s_axis_tdata[27:12];
                in_frac = s_axis_tdata[59:28];
                if (s_axis_tuser[0] == CMD_WRITE)
                    weight_grid[in_row][in_col] = in_wgt;
                else
                    expected_picks.push_back(predict_pick(in_frac));
            end
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// tb: stimulus and verdict for grid_roulette_wheel_sampler
// drives weight writes, draws and region settings; checking lives in grws_pick_checker
// depends on grws_pkg and the sampler rtl
`timescale 1ns / 1ps

module tb;
    import grws_pkg::*;

    // the limit covers the slowest legal run (reset clear, one slow region,
    // worst gaps and stalls on every item) with ample margin
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 3000;
    // a write lands in the memories in the S_WR_UPD state after it is taken
    localparam int SETTLE       = 8;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_BITS-1:0]    i_cfg_idx;
    logic [COORD_BITS-1:0]      i_cfg_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // cell_col[5:0], cell_row[11:6], cell_weight[27:12],
    // random_fraction[59:28], zero pad[63:60]
    logic [IN_TDATA_BITS-1:0]   s_axis_tdata;
    // command[0]
    logic [0:0]                 s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // pick_col[5:0], pick_row[11:6], zero pad[15:12]
    logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;

    int mismatches, picks_outstanding, picks_checked;

    // sender / receiver pacing controls
    bit tx_gapless;
    bit rx_gapless;
    bit rx_hold_req;
    int hold_count;

    // current region, mirrored for aiming writes into the rectangle
    logic [COORD_BITS-1:0] cur_left, cur_right, cur_bottom, cur_top;
    int items_sent, draws_sent, region_count;
    int cycles;

    grid_roulette_wheel_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    grws_pick_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .o_mismatches        (mismatches),
        .o_picks_outstanding (picks_outstanding),
        .o_picks_checked     (picks_checked)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
    end

    // result receiver: random stall per item, gapless stretches, one long hold
    initial begin : receiver
        int wait_cycles;
        int taken;
        m_axis_tready = 1'b0;
        rx_gapless    = 1'b0;
        taken         = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 24 == 0)
                rx_gapless = ($urandom_range(0, 3) == 0);
            wait_cycles = rx_gapless ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_req) begin
                // long hold-off so the block fills and stalls its input
                wait_cycles = HOLD_CYCLES;
                rx_hold_req = 1'b0;
                hold_count++;
            end
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
            taken++;
        end
    end

    // program all four region registers, one per cycle; block must be idle
    task automatic set_region(input logic [COORD_BITS-1:0] l, r, b, t);
        t_cfg_idx              idx_list [4];
        logic [COORD_BITS-1:0] val_list [4];
        idx_list = '{CFG_LEFT, CFG_RIGHT, CFG_BOTTOM, CFG_TOP};
        val_list = '{l, r, b, t};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(negedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cur_left   = l;
        cur_right  = r;
        cur_bottom = b;
        cur_top    = t;
        region_count++;
    endtask

    // offer one item after a random gap; returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [COORD_BITS-1:0] col, row,
                             input logic [IN_WEIGHT_BITS-1:0] wgt,
                             input logic [FRAC_BITS-1:0] frac);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {4'd0, frac, wgt, row, col};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        if (cmd == CMD_DRAW)
            draws_sent++;
    endtask

    // sender goes quiet until every pick is back and the last write has landed
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (picks_outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // random traffic: mostly writes aimed into the rectangle plus draws,
    // with some writes anywhere on the grid
    task automatic run_phase(input int n);
        int unsigned               x1, x2, y1, y2;
        int                        kind, q;
        logic [COORD_BITS-1:0]     col, row;
        logic [IN_WEIGHT_BITS-1:0] wgt;
        logic [FRAC_BITS-1:0]      frac;
        x1 = cur_left;
        x2 = (cur_right < cur_left) ? cur_left : cur_right;
        y1 = cur_bottom;
        y2 = (cur_top < cur_bottom) ? cur_bottom : cur_top;
        for (int i = 0; i < n; i++) begin
            if (i % 32 == 0)
                tx_gapless = ($urandom_range(0, 3) == 0);
            q = $urandom_range(0, 9);
            case (q)
                0:       wgt = '0;
                1:       wgt = '1;
                2:       wgt = $urandom_range(1, 15);
                default: wgt = $urandom;
            endcase
            q = $urandom_range(0, 9);
            case (q)
                0:       frac = '0;
                1:       frac = '1;
                default: frac = $urandom;
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                col = $urandom_range(x2, x1);
                row = $urandom_range(y2, y1);
                send_item(CMD_WRITE, col, row, wgt, frac);
            end else if (kind < 55) begin
                col = $urandom_range(0, 63);
                row = $urandom_range(0, 63);
                send_item(CMD_WRITE, col, row, wgt, frac);
            end else begin
                col = $urandom_range(0, 63);
                row = $urandom_range(0, 63);
                send_item(CMD_DRAW, col, row, wgt, frac);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_LEFT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        tx_gapless    = 1'b0;
        rx_hold_req   = 1'b0;
        hold_count    = 0;
        items_sent    = 0;
        draws_sent    = 0;
        region_count  = 0;
        cur_left      = LEFT_RESET;
        cur_right     = RIGHT_RESET;
        cur_bottom    = BOTTOM_RESET;
        cur_top       = TOP_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, at reset region (whole grid)
        // zero total: any fraction lands on the first cell
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'hFFFF_FFFF);
        // single heavy corner cell; zero-weight leading rows win when the target is 0
        send_item(CMD_WRITE, 6'd63, 6'd63, 16'hFFFF, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 6'd0,  6'd0,  16'h0001, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 6'd21, 6'd42, 16'hAAAA, 32'h5555_5555);
        send_item(CMD_WRITE, 6'd42, 6'd21, 16'h5555, 32'hAAAA_AAAA);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0001);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h8000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h7FFF_FFFF);
        // overwrite drops the corner back out of its row total
        send_item(CMD_WRITE, 6'd63, 6'd63, 16'h0000, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 6'd0,  6'd0,  16'h0000, 32'h0000_0000);
        send_item(CMD_WRITE, 6'd63, 6'd0,  16'hFFFF, 32'h0000_0000);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'h5555_5555);
        send_item(CMD_DRAW,  6'd0,  6'd0,  16'h0000, 32'hAAAA_AAAA);

        // region sweep; each change only after the block has gone idle
        drain(); set_region(6'd0,  6'd63, 6'd0,  6'd63); run_phase(300);
        drain(); set_region(6'd0,  6'd63, 6'd10, 6'd20); run_phase(250);
        drain(); set_region(6'd5,  6'd12, 6'd3,  6'd9);  run_phase(250);
        // both bounds inverted: single cell at (40, 50)
        drain(); set_region(6'd40, 6'd30, 6'd50, 6'd20); run_phase(150);
        // inverted rows: top row only, full width
        drain(); set_region(6'd0,  6'd63, 6'd63, 6'd0);  run_phase(100);
        drain(); set_region(6'd63, 6'd0,  6'd63, 6'd0);  run_phase(60);
        // not full width, so every row is summed cell by cell: slow draws, few items
        drain(); set_region(6'd0,  6'd62, 6'd0,  6'd63); run_phase(20);
        drain(); set_region(6'd1,  6'd63, 6'd0,  6'd0);  run_phase(150);
        drain(); set_region(6'd20, 6'd20, 6'd0,  6'd63); run_phase(150);
        // whole grid again with a long receiver hold-off while items keep coming
        drain(); set_region(6'd0,  6'd63, 6'd0,  6'd63);
        rx_hold_req = 1'b1;
        run_phase(200);

        drain();
        repeat (20) @(negedge i_clk);
        $display("tb: %0d items sent (%0d draws) across %0d region settings",
                 items_sent, draws_sent, region_count);
        $display("tb: %0d picks compared, %0d long output hold-offs, %0d mismatches",
                 picks_checked, hold_count, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
